// File: rtl/tss_pkg.sv
`default_nettype none

package tss_pkg;

    // Default sizes of the problem
    localparam int MAX_VARS_DEF    = 64;
    localparam int MAX_CLAUSES_DEF = 256;
    localparam logic [6:0] NUM_VARS_RESET = 7'd64;

    // Request codes
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SOLVE = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic signed [7:0] lit_a;
        logic signed [7:0] lit_b;
    } in_word_t;

    typedef struct packed {
        logic        satisfiable;
        logic [63:0] assignment;
        logic        input_error;
        logic [8:0]  clauses_used;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FW_NEXT,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_POP_WAIT,
        ST_TR_NEXT,
        ST_TR_LOAD,
        ST_CK_RD1,
        ST_CK_RD2,
        ST_CK_EV,
        ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        CMD_NOP,
        CMD_ADD,
        CMD_SOLVE_INIT,
        CMD_FW_SKIP,
        CMD_FW_START,
        CMD_CLAUSE_RD,
        CMD_FINISH,
        CMD_POP_LOAD,
        CMD_PUSH,
        CMD_ADVANCE,
        CMD_TR_INIT,
        CMD_TR_ISSUE,
        CMD_TR_START,
        CMD_CK_INIT,
        CMD_CK_RD1,
        CMD_CK_RD2,
        CMD_CK_EVAL,
        CMD_OUT_LOAD
    } cmd_t;

    typedef struct packed {
        logic fw_done;
        logic iter_visited;
        logic scan_end;
        logic sp_one;
        logic hit;
        logic trans;
        logic tr_zero;
        logic tr_visited;
        logic ck_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/two_sat_solver_top.sv
// Add word: accepted in the cycle it is offered while idle, one clause per cycle, no result word.
// Solve word (N variables, C clauses): nodes are stepped forward and then on the transpose;
// each node scans all 2C edges, each edge a clause read then a test; finishing a node and
// resuming its parent are separate steps; the check then reads both components of each
// variable, and the result word loads once the output register is free.
// Input is held off for the whole solve. Reset clears clause count and error; num_vars is 64.
`default_nettype none

module two_sat_solver_top
    import tss_pkg::*;
#(
    parameter int MAX_VARS    = MAX_VARS_DEF,
    parameter int MAX_CLAUSES = MAX_CLAUSES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire in_word_t   in_data,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [6:0] cfg_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_word_t       out_data
);

    cmd_t    cmd;
    status_t status;

    // Take a config word at any time
    assign cfg_ready = 1'b1;

    tss_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_req_type (in_data.req_type),
        .status      (status),
        .in_ready    (in_ready),
        .cmd         (cmd)
    );

    tss_dp #(
        .MAX_VARS    (MAX_VARS),
        .MAX_CLAUSES (MAX_CLAUSES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_ready (out_ready),
        .status    (status),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// File: rtl/tss_ram.sv
`default_nettype none

module tss_ram #(
    parameter int W = 8,
    parameter int D = 16,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [W-1:0]  wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [W-1:0]  rdata
);

    logic [W-1:0] mem [D];

    // Write one word, read one word registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/tss_ctrl.sv
`default_nettype none

module tss_ctrl
    import tss_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    input  wire logic    in_req_type,
    input  wire status_t status,
    output logic         in_ready,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_req_type == REQ_SOLVE)
                begin
                    state_next = ST_FW_NEXT;
                end
            end
            ST_FW_NEXT:
            begin
                if (status.fw_done)
                begin
                    state_next = ST_TR_NEXT;
                end
                else if (!status.iter_visited)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD:
            begin
                if (!status.scan_end)
                begin
                    state_next = ST_SCAN_EV;
                end
                else if (!status.sp_one)
                begin
                    state_next = ST_POP_WAIT;
                end
                else if (status.trans)
                begin
                    state_next = ST_TR_NEXT;
                end
                else
                begin
                    state_next = ST_FW_NEXT;
                end
            end
            ST_SCAN_EV:  state_next = ST_SCAN_RD;
            ST_POP_WAIT: state_next = ST_SCAN_RD;
            ST_TR_NEXT:  state_next = status.tr_zero ? ST_CK_RD1 : ST_TR_LOAD;
            ST_TR_LOAD:  state_next = status.tr_visited ? ST_TR_NEXT : ST_SCAN_RD;
            ST_CK_RD1:   state_next = status.ck_done ? ST_DONE : ST_CK_RD2;
            ST_CK_RD2:   state_next = ST_CK_EV;
            ST_CK_EV:    state_next = ST_CK_RD1;
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Command decode
    always_comb
    begin
        cmd      = CMD_NOP;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd = (in_req_type == REQ_SOLVE) ? CMD_SOLVE_INIT : CMD_ADD;
                end
            end
            ST_FW_NEXT:
            begin
                if (status.fw_done)
                begin
                    cmd = CMD_TR_INIT;
                end
                else if (status.iter_visited)
                begin
                    cmd = CMD_FW_SKIP;
                end
                else
                begin
                    cmd = CMD_FW_START;
                end
            end
            ST_SCAN_RD:  cmd = status.scan_end ? CMD_FINISH : CMD_CLAUSE_RD;
            ST_SCAN_EV:  cmd = status.hit ? CMD_PUSH : CMD_ADVANCE;
            ST_POP_WAIT: cmd = CMD_POP_LOAD;
            ST_TR_NEXT:  cmd = status.tr_zero ? CMD_CK_INIT : CMD_TR_ISSUE;
            ST_TR_LOAD:  cmd = status.tr_visited ? CMD_NOP : CMD_TR_START;
            ST_CK_RD1:   cmd = status.ck_done ? CMD_NOP : CMD_CK_RD1;
            ST_CK_RD2:   cmd = CMD_CK_RD2;
            ST_CK_EV:    cmd = CMD_CK_EVAL;
            ST_DONE:     cmd = status.out_free ? CMD_OUT_LOAD : CMD_NOP;
            default:     cmd = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tss_dp.sv
`default_nettype none

module tss_dp
    import tss_pkg::*;
#(
    parameter int MAX_VARS    = MAX_VARS_DEF,
    parameter int MAX_CLAUSES = MAX_CLAUSES_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cmd_t       cmd,
    input  wire in_word_t   in_data,
    input  wire logic       cfg_valid,
    input  wire logic [6:0] cfg_data,
    input  wire logic       out_ready,
    output status_t         status,
    output logic            out_valid,
    output out_word_t       out_data
);

    localparam int NODES = 2 * MAX_VARS;
    localparam int IW    = $clog2(NODES);
    localparam int NW    = $clog2(NODES + 1);
    localparam int TW    = NW + 1;
    localparam int CW    = $clog2(MAX_CLAUSES + 1);
    localparam int EW    = CW + 1;
    localparam int AW    = (MAX_CLAUSES > 1) ? $clog2(MAX_CLAUSES) : 1;
    localparam int SW    = IW + EW;

    // Control and walk registers
    logic [6:0]       num_vars_reg;
    logic [CW-1:0]    count_reg;
    logic             err_reg;
    logic             trans_reg;
    logic [NODES-1:0] vis_reg;
    logic [TW-1:0]    iter_reg;
    logic [NW-1:0]    fcount_reg;
    logic [IW-1:0]    comp_reg;
    logic [NW-1:0]    u_reg;
    logic [EW-1:0]    e_reg;
    logic [NW-1:0]    sp_reg;
    logic [IW-1:0]    comp_a_reg;
    logic             sat_reg;
    logic [63:0]      assign_reg;
    logic             out_valid_reg;
    out_word_t        out_reg;

    logic [6:0] n_eff;
    logic [7:0] n8;
    logic [7:0] u8;

    // RAM ports
    logic          cl_we, cl_re;
    logic [AW-1:0] cl_waddr, cl_raddr;
    logic [13:0]   cl_wdata, cl_rdata;
    logic          st_we, st_re;
    logic [IW-1:0] st_waddr, st_raddr;
    logic [SW-1:0] st_wdata, st_rdata;
    logic          fn_we, fn_re;
    logic [IW-1:0] fn_waddr, fn_raddr;
    logic [IW-1:0] fn_rdata;
    logic          cm_we, cm_re;
    logic [IW-1:0] cm_waddr, cm_raddr;
    logic [IW-1:0] cm_rdata;

    // Add decode
    logic [7:0] a_u, b_u, a_mag, b_mag;
    logic       add_bad;
    logic [6:0] code_a, code_b;

    // Edge decode
    logic [6:0] ca, cb;
    logic [7:0] pos_a, pos_b, node_a, node_b, neg_a, neg_b;
    logic [7:0] src8, dst8, from8, to8;
    logic       clause_ok;
    logic [IW-1:0] to_idx;
    logic          hit;
    logic [7:0]    tr_node8;

    // Clamp variable count
    always_comb
    begin
        if (num_vars_reg == 7'd0)
        begin
            n_eff = 7'd1;
        end
        else if (num_vars_reg > 7'(MAX_VARS))
        begin
            n_eff = 7'(MAX_VARS);
        end
        else
        begin
            n_eff = num_vars_reg;
        end
    end

    assign n8 = {1'b0, n_eff};
    assign u8 = 8'(u_reg);

    // Check and encode the incoming clause
    always_comb
    begin
        a_u    = in_data.lit_a;
        b_u    = in_data.lit_b;
        a_mag  = a_u[7] ? (~a_u + 8'd1) : a_u;
        b_mag  = b_u[7] ? (~b_u + 8'd1) : b_u;
        add_bad = (a_u == 8'd0) || (b_u == 8'd0) || (a_mag > n8) || (b_mag > n8)
                  || (count_reg >= CW'(MAX_CLAUSES));
        code_a = {a_u[7], 6'(a_mag - 8'd1)};
        code_b = {b_u[7], 6'(b_mag - 8'd1)};
    end

    // Decode the edge under the scan pointer
    always_comb
    begin
        ca        = cl_rdata[13:7];
        cb        = cl_rdata[6:0];
        clause_ok = ({1'b0, ca[5:0]} < n_eff) && ({1'b0, cb[5:0]} < n_eff);
        pos_a     = 8'(ca[5:0]) + 8'd1;
        pos_b     = 8'(cb[5:0]) + 8'd1;
        node_a    = ca[6] ? n8 + pos_a : pos_a;
        node_b    = cb[6] ? n8 + pos_b : pos_b;
        neg_a     = ca[6] ? pos_a : n8 + pos_a;
        neg_b     = cb[6] ? pos_b : n8 + pos_b;
        src8      = e_reg[0] ? neg_b : neg_a;
        dst8      = e_reg[0] ? node_a : node_b;
        from8     = trans_reg ? dst8 : src8;
        to8       = trans_reg ? src8 : dst8;
        to_idx    = IW'(to8 - 8'd1);
        hit       = clause_ok && (from8 == u8) && !vis_reg[to_idx];
        tr_node8  = 8'(fn_rdata) + 8'd1;
    end

    // Status to the controller
    always_comb
    begin
        status.fw_done      = iter_reg > TW'({n8, 1'b0});
        status.iter_visited = vis_reg[IW'(iter_reg - TW'(1))];
        status.scan_end     = e_reg >= {count_reg, 1'b0};
        status.sp_one       = sp_reg == NW'(1);
        status.hit          = hit;
        status.trans        = trans_reg;
        status.tr_zero      = iter_reg == TW'(0);
        status.tr_visited   = vis_reg[fn_rdata];
        status.ck_done      = iter_reg > TW'(n8);
        status.out_free     = !out_valid_reg || out_ready;
    end

    // RAM port steering
    always_comb
    begin
        cl_we    = (cmd == CMD_ADD) && !add_bad;
        cl_waddr = AW'(count_reg);
        cl_wdata = {code_a, code_b};
        cl_re    = cmd == CMD_CLAUSE_RD;
        cl_raddr = AW'(e_reg >> 1);

        st_we    = cmd == CMD_PUSH;
        st_waddr = IW'(sp_reg - NW'(1));
        st_wdata = {IW'(u8 - 8'd1), e_reg + EW'(1)};
        st_re    = (cmd == CMD_FINISH) && !status.sp_one;
        st_raddr = IW'(sp_reg - NW'(2));

        fn_we    = (cmd == CMD_FINISH) && !trans_reg;
        fn_waddr = IW'(fcount_reg);
        fn_re    = cmd == CMD_TR_ISSUE;
        fn_raddr = IW'(iter_reg - TW'(1));

        cm_we    = trans_reg && ((cmd == CMD_PUSH) || (cmd == CMD_TR_START));
        cm_waddr = (cmd == CMD_PUSH) ? to_idx : fn_rdata;
        cm_re    = (cmd == CMD_CK_RD1) || (cmd == CMD_CK_RD2);
        cm_raddr = (cmd == CMD_CK_RD1) ? IW'(iter_reg - TW'(1))
                                       : IW'(iter_reg + TW'(n8) - TW'(1));
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg  <= NUM_VARS_RESET;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            trans_reg     <= 1'b0;
            vis_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                num_vars_reg <= cfg_data;
            end
            // Raise valid on a fresh result, drop it once the word is taken
            if (cmd == CMD_OUT_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd)
                CMD_ADD:
                begin
                    if (add_bad)
                    begin
                        err_reg <= 1'b1;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                CMD_SOLVE_INIT:
                begin
                    vis_reg   <= '0;
                    trans_reg <= 1'b0;
                end
                CMD_FW_START:
                begin
                    vis_reg[IW'(iter_reg - TW'(1))] <= 1'b1;
                end
                CMD_TR_START:
                begin
                    vis_reg[fn_rdata] <= 1'b1;
                end
                CMD_PUSH:
                begin
                    vis_reg[to_idx] <= 1'b1;
                end
                CMD_ADVANCE:
                begin
                    if (!clause_ok)
                    begin
                        err_reg <= 1'b1;
                    end
                end
                CMD_TR_INIT:
                begin
                    vis_reg   <= '0;
                    trans_reg <= 1'b1;
                end
                CMD_OUT_LOAD:
                begin
                    count_reg     <= '0;
                    err_reg       <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Walk and result datapath
    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_SOLVE_INIT:
            begin
                iter_reg   <= TW'(1);
                fcount_reg <= '0;
            end
            CMD_FW_SKIP:
            begin
                iter_reg <= iter_reg + TW'(1);
            end
            CMD_FW_START:
            begin
                u_reg    <= NW'(iter_reg);
                e_reg    <= '0;
                sp_reg   <= NW'(1);
                iter_reg <= iter_reg + TW'(1);
            end
            CMD_FINISH:
            begin
                if (!trans_reg)
                begin
                    fcount_reg <= fcount_reg + NW'(1);
                end
                if (status.sp_one)
                begin
                    sp_reg <= '0;
                    if (trans_reg)
                    begin
                        comp_reg <= comp_reg + IW'(1);
                    end
                end
            end
            CMD_POP_LOAD:
            begin
                u_reg  <= NW'(8'(st_rdata[SW-1:EW]) + 8'd1);
                e_reg  <= st_rdata[EW-1:0];
                sp_reg <= sp_reg - NW'(1);
            end
            CMD_PUSH:
            begin
                u_reg  <= NW'(to8);
                e_reg  <= '0;
                sp_reg <= sp_reg + NW'(1);
            end
            CMD_ADVANCE:
            begin
                e_reg <= e_reg + EW'(1);
            end
            CMD_TR_INIT:
            begin
                iter_reg <= TW'(fcount_reg);
                comp_reg <= '0;
            end
            CMD_TR_ISSUE:
            begin
                iter_reg <= iter_reg - TW'(1);
            end
            CMD_TR_START:
            begin
                u_reg  <= NW'(tr_node8);
                e_reg  <= '0;
                sp_reg <= NW'(1);
            end
            CMD_CK_INIT:
            begin
                iter_reg   <= TW'(1);
                sat_reg    <= 1'b1;
                assign_reg <= '0;
            end
            CMD_CK_RD2:
            begin
                comp_a_reg <= cm_rdata;
            end
            CMD_CK_EVAL:
            begin
                if (comp_a_reg == cm_rdata)
                begin
                    sat_reg <= 1'b0;
                end
                if (comp_a_reg > cm_rdata)
                begin
                    assign_reg[6'(iter_reg - TW'(1))] <= 1'b1;
                end
                iter_reg <= iter_reg + TW'(1);
            end
            CMD_OUT_LOAD:
            begin
                out_reg.satisfiable  <= sat_reg;
                out_reg.assignment   <= sat_reg ? assign_reg : 64'd0;
                out_reg.input_error  <= err_reg;
                out_reg.clauses_used <= 9'(count_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    tss_ram #(.W(14), .D(MAX_CLAUSES)) u_clause_ram (
        .clk   (clk),
        .we    (cl_we),
        .waddr (cl_waddr),
        .wdata (cl_wdata),
        .re    (cl_re),
        .raddr (cl_raddr),
        .rdata (cl_rdata)
    );

    tss_ram #(.W(SW), .D(NODES)) u_stack_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    tss_ram #(.W(IW), .D(NODES)) u_finish_ram (
        .clk   (clk),
        .we    (fn_we),
        .waddr (fn_waddr),
        .wdata (IW'(u8 - 8'd1)),
        .re    (fn_re),
        .raddr (fn_raddr),
        .rdata (fn_rdata)
    );

    tss_ram #(.W(IW), .D(NODES)) u_comp_ram (
        .clk   (clk),
        .we    (cm_we),
        .waddr (cm_waddr),
        .wdata (comp_reg),
        .re    (cm_re),
        .raddr (cm_raddr),
        .rdata (cm_rdata)
    );

endmodule

`default_nettype wire
